>>> hdl/plb_pkg.sv
// Package for the pixel layer blend core: mode codes, widths, shared types.
// No dependencies.
package plb_pkg;
    localparam int PIX_W = 8;
    localparam int MODE_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_MULTIPLY = 4'd0, MODE_DIVIDE = 4'd1, MODE_OVERLAY = 4'd2,
        MODE_SCREEN = 4'd3, MODE_DISSOLVE = 4'd4, MODE_DODGE = 4'd5,
        MODE_BURN = 4'd6, MODE_HARDLIGHT = 4'd7, MODE_SOFTLIGHT = 4'd8,
        MODE_GRAIN_EXTRACT = 4'd9, MODE_GRAIN_MERGE = 4'd10,
        MODE_DIFFERENCE = 4'd11, MODE_ADDITION = 4'd12,
        MODE_SUBTRACT = 4'd13, MODE_DARKEN = 4'd14, MODE_LIGHTEN = 4'd15
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] lower_value;
        logic [PIX_W-1:0] upper_value;
        logic             coin;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] blended_value;
        logic             clipped;
    } t_out_item;
endpackage

>>> hdl/plb_stream_if.sv
// Valid/ready stream channel carrying one payload of parameter type.
// Depends on nothing; payload types come from plb_pkg.
interface plb_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/plb_divider.sv
// Pipelined restoring divider, one quotient bit per stage, plus clamp/clip.
// Depends on plb_pkg.
module plb_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic                         i_neg,
    input  logic [24:0]                  i_num,
    input  logic [16:0]                  i_den,
    output logic                         o_valid,
    output logic [plb_pkg::PIX_W-1:0]    o_value,
    output logic                         o_clipped
);
    import plb_pkg::*;
    // num < 2^25 (max 255*65025); quotient beyond 255 only matters as overflow.
    localparam int STG = 9;
    logic        r_v   [STG+1];
    logic        r_neg [STG+1];
    logic        r_ovf [STG+1];
    logic [24:0] r_rem [STG+1];
    logic [16:0] r_den [STG+1];
    logic [8:0]  r_q   [STG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
        if (i_adv) begin
            r_neg[0] <= i_neg;
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            // num > 255*den  <=> quotient >= 256 or (q==255 and rem>0)
            r_ovf[0] <= 1'b0;
        end
    end

    for (genvar s = 0; s < STG; s++) begin : g_stg
        localparam int SH = 8 - s;
        logic [25:0] w_d;
        logic        w_ge;
        assign w_d  = {9'd0, r_den[s]} << SH;
        assign w_ge = {1'b0, r_rem[s]} >= w_d;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[s+1] <= r_v[s];
            end
            if (i_adv) begin
                r_neg[s+1] <= r_neg[s];
                r_den[s+1] <= r_den[s];
                r_ovf[s+1] <= r_ovf[s];
                r_rem[s+1] <= w_ge ? r_rem[s] - w_d[24:0] : r_rem[s];
                r_q[s+1]   <= {r_q[s][7:0], w_ge};
            end
        end
    end

    logic w_big;
    assign w_big = r_q[STG][8] || (r_q[STG][7:0] == 8'hFF && r_rem[STG] != 25'd0);
    assign o_valid   = r_v[STG];
    assign o_value   = r_neg[STG] ? '0 : (r_q[STG][8] ? 8'hFF : r_q[STG][7:0]);
    assign o_clipped = r_neg[STG] || w_big || r_ovf[STG];
endmodule

>>> hdl/plb_formula.sv
// Formula stages: product terms (stage 1), numerator/denominator (stage 2).
// Depends on plb_pkg.
module plb_formula (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  plb_pkg::t_mode         i_mode,
    input  plb_pkg::t_in_item      i_item,
    output logic                   o_valid,
    output logic                   o_neg,
    output logic [24:0]            o_num,
    output logic [16:0]            o_den
);
    import plb_pkg::*;
    logic        r_v1, r_v2;
    t_mode       r_mode;
    logic [8:0]  r_m, r_i;
    logic        r_coin;
    logic [16:0] r_p1, r_p2;
    logic [25:0] n_p1, n_p2;
    logic signed [27:0] n_num;
    logic [16:0] n_den;
    logic        r_neg;
    logic [24:0] r_num;
    logic [16:0] r_den;
    logic [8:0]  w_m, w_i, w_cm, w_ci;

    assign w_m = {1'b0, i_item.lower_value};
    assign w_i = {1'b0, i_item.upper_value};
    assign w_cm = 9'd255 - w_m;
    assign w_ci = 9'd255 - w_i;

    // stage 1: up to two 9x9 products per mode
    always_comb begin
        n_p1 = '0;
        n_p2 = '0;
        case (i_mode)
            MODE_MULTIPLY, MODE_HARDLIGHT: begin
                n_p1 = 26'(w_m * w_i);
                n_p2 = 26'(w_ci * (9'd511 - {w_m[7:0], 1'b0}));
            end
            MODE_OVERLAY: begin
                n_p1 = 26'(w_i * w_i);
                n_p2 = 26'(w_m * w_ci);
            end
            MODE_SCREEN, MODE_SOFTLIGHT: begin
                n_p1 = 26'(w_cm * w_ci);
                n_p2 = 26'(w_m * w_ci);
            end
            default: begin
                n_p1 = '0;
                n_p2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_adv) begin
            r_mode <= i_mode;
            r_m    <= w_m;
            r_i    <= w_i;
            r_coin <= i_item.coin;
            r_p1   <= n_p1[16:0];
            r_p2   <= n_p2[16:0];
            r_neg  <= n_num < 0;
            r_num  <= n_num < 0 ? '0 : n_num[24:0];
            r_den  <= n_den;
        end
    end

    // Stage 2: products here are by 255/256 style constants and one 9x18 for
    // overlay/softlight, whose full numerators go over 65025.
    logic [33:0] w_t;
    always_comb begin
        w_t   = '0;
        n_num = '0;
        n_den = 17'd1;
        case (r_mode)
            MODE_MULTIPLY: begin
                n_num = 28'(r_p1);
                n_den = 17'd255;
            end
            MODE_DIVIDE: begin
                n_num = 28'({r_i, 8'd0});
                n_den = 17'(r_m + 9'd1);
            end
            MODE_OVERLAY: begin
                // i*(255 i + 2 m(255-i)) / 65025 = (255*ii + 2*i*p2)/65025
                w_t   = 34'(r_i * ({r_p2, 1'b0}));
                n_num = 28'(34'(r_p1) * 34'd255 + w_t);
                n_den = 17'd65025;
            end
            MODE_SCREEN: begin
                n_num = 28'(17'd65025 - r_p1);
                n_den = 17'd255;
            end
            MODE_DISSOLVE: n_num = 28'(r_coin ? r_m : r_i);
            MODE_DODGE: begin
                n_num = 28'({r_i, 8'd0});
                n_den = 17'(9'd256 - r_m);
            end
            MODE_BURN: begin
                n_num = 28'(18'(r_m + 9'd1) * 18'd255) - 28'({9'd255 - r_i, 8'd0});
                n_den = 17'(r_m + 9'd1);
            end
            MODE_HARDLIGHT: begin
                if (r_m > 9'd128) begin
                    n_num = 28'd65280 - 28'(r_p2);
                    n_den = 17'd256;
                end else begin
                    n_num = 28'(r_p1);
                    n_den = 17'd128;
                end
            end
            MODE_SOFTLIGHT: begin
                // (p2*i + i*(65025-p1)) / 65025
                w_t   = 34'(r_i * (r_p2 + (17'd65025 - r_p1)));
                n_num = 28'(w_t);
                n_den = 17'd65025;
            end
            MODE_GRAIN_EXTRACT: n_num = 28'(r_i) - 28'(r_m) + 28'd128;
            MODE_GRAIN_MERGE:   n_num = 28'(r_i) + 28'(r_m) - 28'd128;
            MODE_DIFFERENCE:    n_num = 28'(r_i >= r_m ? r_i - r_m : r_m - r_i);
            MODE_ADDITION:      n_num = 28'(r_i + r_m);
            MODE_SUBTRACT:      n_num = 28'(r_i) - 28'(r_m);
            MODE_DARKEN:        n_num = 28'(r_m < r_i ? r_m : r_i);
            default:            n_num = 28'(r_m > r_i ? r_m : r_i);
        endcase
    end

    assign o_valid = r_v2;
    assign o_neg   = r_neg;
    assign o_num   = r_num;
    assign o_den   = r_den;
endmodule

>>> hdl/pixel_layer_blend_core.sv
// Pixel layer blend core: top level with input/output streams and mode register.
// Depends on plb_pkg, plb_stream_if, plb_formula, plb_divider.
//
// Usage:
//   i_in carries lower_value, upper_value and coin; o_out carries
//   blended_value and clipped. One transfer per clock is sustained while
//   o_out.ready is high. The mode register is written through i_cfg_we /
//   i_cfg_data; the user must do so only while idle, the block does not
//   enforce it. Data passes two formula stages, ten divider stages (input
//   register plus nine quotient bits) and one output register.
//   The whole pipeline advances when the output register is empty or taken;
//   when the receiver stalls, every stage holds and i_in.ready drops.
//   Reset clears all valid bits and sets the mode to multiply.
module pixel_layer_blend_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [plb_pkg::MODE_W-1:0]  i_cfg_data,
    plb_stream_if.sink                  i_in,
    plb_stream_if.source                o_out
);
    import plb_pkg::*;
    t_mode       r_mode;
    logic        w_adv;
    logic        w_fv, w_fneg, w_dv, w_dclip;
    logic [24:0] w_fnum;
    logic [16:0] w_fden;
    logic [PIX_W-1:0] w_dval;
    logic        r_ov;
    t_out_item   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mode <= MODE_MULTIPLY;
        else if (i_cfg_we) r_mode <= t_mode'(i_cfg_data);
    end

    assign w_adv = !r_ov || o_out.ready;
    assign i_in.ready = w_adv;

    plb_formula u_formula (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(i_in.valid),
        .i_mode(r_mode), .i_item(i_in.data), .o_valid(w_fv), .o_neg(w_fneg),
        .o_num(w_fnum), .o_den(w_fden)
    );

    plb_divider u_divider (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(w_fv),
        .i_neg(w_fneg), .i_num(w_fnum), .i_den(w_fden), .o_valid(w_dv),
        .o_value(w_dval), .o_clipped(w_dclip)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= w_dv;
        if (w_adv) begin
            r_out.blended_value <= w_dval;
            r_out.clipped       <= w_dclip;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_out)) else $error("output lost");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ov |-> i_in.ready) else $error("stalled while empty");
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.clipped |-> (r_out.blended_value == 8'd0 ||
                                   r_out.blended_value == 8'hFF))
        else $error("clipped value off the rails");
endmodule

>>> tb/tb_pixel_layer_blend_core.sv
// Testbench for pixel_layer_blend_core: directed pixel pairs under every blend mode and random
// pairs under random modes, checked against an in-bench integer predictor with random stalls
// on both streams. Depends on plb_pkg, plb_stream_if and the RTL of the core.
`timescale 1ns / 100ps

module tb_pixel_layer_blend_core;
    import plb_pkg::*;

    localparam int LATENCY   = 13;
    localparam int MAX_CYCLE = 400000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [MODE_W-1:0] i_cfg_data;

    plb_stream_if #(.T(t_in_item))  in_ch ();
    plb_stream_if #(.T(t_out_item)) out_ch ();

    pixel_layer_blend_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    t_mode     cur_mode;
    t_in_item  pixel_q[$];
    t_out_item blend_q[$];
    int        n_err;
    int        n_sent;
    int        n_got;
    int        cycle;
    int        src_idle;
    int        snk_idle;
    bit        no_idle;
    bit        hold_off;
    bit        in_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_item blend_pixel(t_mode md, t_in_item it);
        longint m, i, num, den, q;
        t_out_item r;
        m = it.lower_value;
        i = it.upper_value;
        num = 0;
        den = 1;
        case (md)
            MODE_MULTIPLY: begin num = m * i; den = 255; end
            MODE_DIVIDE: begin num = i * 256; den = m + 1; end
            MODE_OVERLAY: begin num = i * (255 * i + 2 * m * (255 - i)); den = 65025; end
            MODE_SCREEN: begin num = 65025 - (255 - m) * (255 - i); den = 255; end
            MODE_DISSOLVE: num = it.coin ? m : i;
            MODE_DODGE: begin num = i * 256; den = 256 - m; end
            MODE_BURN: begin num = 255 * (m + 1) - 256 * (255 - i); den = m + 1; end
            MODE_HARDLIGHT: begin
                if (m > 128) begin
                    num = 65280 - (255 - i) * (511 - 2 * m);
                    den = 256;
                end else begin
                    num = i * m;
                    den = 128;
                end
            end
            MODE_SOFTLIGHT: begin
                num = (255 - i) * m * i + i * (65025 - (255 - m) * (255 - i));
                den = 65025;
            end
            MODE_GRAIN_EXTRACT: num = i - m + 128;
            MODE_GRAIN_MERGE: num = i + m - 128;
            MODE_DIFFERENCE: num = (i >= m) ? i - m : m - i;
            MODE_ADDITION: num = m + i;
            MODE_SUBTRACT: num = i - m;
            MODE_DARKEN: num = (m < i) ? m : i;
            default: num = (m > i) ? m : i;
        endcase
        if (num < 0) begin
            r.blended_value = '0;
            r.clipped = 1'b1;
        end else begin
            q = num / den;
            r.clipped = (num > 255 * den);
            r.blended_value = (q > 255) ? 8'd255 : q[7:0];
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
        end else if (pixel_q.size() == 0 || hold_off) begin
            in_ch.valid <= 1'b0;
        end else if (src_idle > 0) begin
            src_idle <= src_idle - 1;
            in_ch.valid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            src_idle <= $urandom_range(1, 7) - 1;
            in_ch.valid <= 1'b0;
        end else begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pixel_q.pop_front();
        end
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (snk_idle > 0) begin
            snk_idle <= snk_idle - 1;
            out_ch.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            snk_idle <= $urandom_range(1, 7) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_px;
        cycle <= cycle + 1;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            blend_q.push_back(blend_pixel(cur_mode, in_ch.data));
            n_sent <= n_sent + 1;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_got <= n_got + 1;
            if (blend_q.size() == 0) begin
                $error("unexpected result transfer");
                n_err = n_err + 1;
            end else begin
                exp_px = blend_q.pop_front();
                if (out_ch.data.blended_value !== exp_px.blended_value) begin
                    $error("blended_value exp %0d got %0d", exp_px.blended_value,
                           out_ch.data.blended_value);
                    n_err = n_err + 1;
                end
                if (out_ch.data.clipped !== exp_px.clipped) begin
                    $error("clipped exp %0d got %0d", exp_px.clipped, out_ch.data.clipped);
                    n_err = n_err + 1;
                end
            end
        end
        if (cycle > MAX_CYCLE) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_in_item rand_pixel();
        t_in_item it;
        it.lower_value = $urandom_range(0, 255);
        it.upper_value = $urandom_range(0, 255);
        it.coin = $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) it.lower_value = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 7) == 0) it.upper_value = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        if ($urandom_range(0, 9) == 0) it.lower_value = 8'd128 + $urandom_range(0, 1);
        return it;
    endfunction

    task automatic drain();
        while (pixel_q.size() != 0 || in_ch.valid || blend_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_mode(t_mode md);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= md;
        cur_mode <= md;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_in_item it;
        int md;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cur_mode = MODE_MULTIPLY;
        n_err = 0; n_sent = 0; n_got = 0; cycle = 0;
        src_idle = 0; snk_idle = 0; no_idle = 0; hold_off = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset-mode multiply, then each mode on corner pairs
        for (md = 0; md < 16; md++) begin
            if (md != 0) set_mode(t_mode'(md));
            for (int a = 0; a < 4; a++) begin
                it.lower_value = (a == 0) ? 8'd0 : (a == 1) ? 8'd255 : (a == 2) ? 8'd128 : 8'd129;
                it.upper_value = (a == 0) ? 8'd255 : (a == 1) ? 8'd0 : (a == 2) ? 8'd255 : 8'd1;
                it.coin = a[0];
                pixel_q.push_back(it);
            end
            it = '{lower_value: 8'd255, upper_value: 8'd255, coin: 1'b1};
            pixel_q.push_back(it);
            drain();
        end

        // random phases, one mode per phase; phase 3 pauses half-way until the pipeline is empty
        for (int ph = 0; ph < 20; ph++) begin
            set_mode(t_mode'($urandom_range(0, 15)));
            if (ph >= 16) no_idle = 1;
            for (int n = 0; n < 50; n++) pixel_q.push_back(rand_pixel());
            if (ph == 3) begin
                while (pixel_q.size() > 25) @(posedge i_clk);
                hold_off = 1;
                while (blend_q.size() != 0 || in_ch.valid) @(posedge i_clk);
                hold_off = 0;
            end
            drain();
        end
        set_mode(MODE_LIGHTEN);
        for (int n = 0; n < 20; n++) pixel_q.push_back(rand_pixel());
        drain();

        $display("Ran %0d pixel transfers over all 16 blend modes, %0d results checked.",
                 n_sent, n_got);
        if (n_err == 0 && blend_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
